[rtl/core/pnci_pkg.sv]
// Shared types, constants and arithmetic helpers of the periodic neighbor cell index generator.
package pnci_pkg;

  localparam int unsigned GRID_MAX        = 64;
  localparam int unsigned DIM_W           = 7;
  localparam int unsigned COORD_W         = 6;
  localparam int unsigned CELL_W          = 18;
  localparam int unsigned TDATA_W         = 24;
  localparam int unsigned PART_W          = 2 * COORD_W;
  localparam int unsigned STEPS_PER_STAGE = 6;
  localparam int unsigned SPLIT_STEPS     = 3 * CELL_W;
  localparam int unsigned SPLIT_STAGES    = SPLIT_STEPS / STEPS_PER_STAGE;
  localparam int unsigned STAGES_PER_AXIS = CELL_W / STEPS_PER_STAGE;
  localparam int unsigned DIM_RESET       = 16;

  // Offset digit codes per axis: step down, stay, step up.
  localparam logic [1:0] DIGIT_MINUS = 2'd0;
  localparam logic [1:0] DIGIT_ZERO  = 2'd1;
  localparam logic [1:0] DIGIT_PLUS  = 2'd2;

  // Register index of grid_dim.
  localparam logic REG_GRID_DIM = 1'b0;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [DIM_W-1:0]   dim_t;
  typedef logic [CELL_W-1:0]  cell_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t z;
  } cell_xyz_t;

  typedef struct packed {
    cell_xyz_t pos;
    logic      last;
  } nbr_t;

  typedef struct packed {
    coord_t rem;
    logic   qbit;
  } div_step_t;

  // One restoring division step; the remainder always stays below dim.
  function automatic div_step_t div_step(coord_t rem, logic bit_in, dim_t dim);
    dim_t      trial;
    div_step_t res;
    trial = {rem, bit_in};
    if (trial >= dim) begin
      res.rem  = COORD_W'(trial - dim);
      res.qbit = 1'b1;
    end else begin
      res.rem  = COORD_W'(trial);
      res.qbit = 1'b0;
    end
    return res;
  endfunction

  // A zero dimension acts as one, a dimension above the grid limit saturates.
  function automatic dim_t eff_dim(dim_t raw);
    dim_t d;
    if (raw == '0) begin
      d = DIM_W'(1);
    end else if (raw > DIM_W'(GRID_MAX)) begin
      d = DIM_W'(GRID_MAX);
    end else begin
      d = raw;
    end
    return d;
  endfunction

  // Periodic shift of one coordinate by the offset that the digit selects.
  function automatic coord_t wrap_coord(coord_t c, logic [1:0] digit, dim_t dim);
    coord_t r;
    case (digit)
      DIGIT_MINUS: begin
        r = (c == '0) ? COORD_W'(dim - DIM_W'(1)) : c - COORD_W'(1);
      end
      DIGIT_PLUS: begin
        r = (({1'b0, c} + DIM_W'(1)) >= dim) ? '0 : c + COORD_W'(1);
      end
      default: begin
        r = c;
      end
    endcase
    return r;
  endfunction

endpackage

[rtl/core/pnci_split.sv]
// Pipelined restoring divider that splits a linear cell index into x, y and z.
module pnci_split (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pnci_pkg::dim_t       dim_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pnci_pkg::cell_t      in_cell_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pnci_pkg::cell_xyz_t  out_pos_o
);

  localparam int unsigned NS = pnci_pkg::SPLIT_STAGES;

  logic             v_q [NS];
  pnci_pkg::cell_t  a_q [NS];
  pnci_pkg::coord_t r_q [NS];
  pnci_pkg::coord_t x_q [NS];
  pnci_pkg::coord_t y_q [NS];
  logic             adv [NS];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    logic             v_in;
    pnci_pkg::cell_t  a_in;
    pnci_pkg::coord_t r_in;
    pnci_pkg::coord_t x_in;
    pnci_pkg::coord_t y_in;
    pnci_pkg::cell_t  a_d;
    pnci_pkg::coord_t r_d;
    logic             take;

    if (k == 0) begin : g_first
      assign v_in = in_valid_i;
      assign a_in = in_cell_i;
      assign r_in = '0;
      assign x_in = '0;
      assign y_in = '0;
    end else begin : g_next
      // At an axis boundary the remainder is the finished coordinate and
      // the quotient becomes the next dividend.
      assign v_in = v_q[k-1];
      assign a_in = a_q[k-1];
      assign r_in = ((k % pnci_pkg::STAGES_PER_AXIS) == 0) ? '0 : r_q[k-1];
      assign x_in = (k == pnci_pkg::STAGES_PER_AXIS) ? r_q[k-1] : x_q[k-1];
      assign y_in = (k == 2 * pnci_pkg::STAGES_PER_AXIS) ? r_q[k-1] : y_q[k-1];
    end

    if (k == NS - 1) begin : g_last_take
      assign take = out_ready_i;
    end else begin : g_mid_take
      assign take = adv[k+1];
    end

    assign adv[k] = !v_q[k] || take;

    always_comb begin
      pnci_pkg::div_step_t st;
      pnci_pkg::cell_t     a;
      pnci_pkg::coord_t    r;
      a = a_in;
      r = r_in;
      for (int s = 0; s < pnci_pkg::STEPS_PER_STAGE; s++) begin
        st = pnci_pkg::div_step(r, a[pnci_pkg::CELL_W-1], dim_i);
        r  = st.rem;
        a  = {a[pnci_pkg::CELL_W-2:0], st.qbit};
      end
      a_d = a;
      r_d = r;
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (adv[k]) begin
        v_q[k] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv[k] && v_in) begin
        a_q[k] <= a_d;
        r_q[k] <= r_d;
        x_q[k] <= x_in;
        y_q[k] <= y_in;
      end
    end
  end

  assign in_ready_o  = adv[0];
  assign out_valid_o = v_q[NS-1];
  assign out_pos_o   = '{x: x_q[NS-1], y: y_q[NS-1], z: r_q[NS-1]};

endmodule

[rtl/core/pnci_gen.sv]
// Sequencer that walks the 27 offset codes of one home cell and wraps each coordinate.
module pnci_gen (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  pnci_pkg::dim_t       dim_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  pnci_pkg::cell_xyz_t  in_pos_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output pnci_pkg::nbr_t       out_nbr_o
);

  logic                hold_v_q;
  pnci_pkg::cell_xyz_t pos_q;
  logic [1:0]          dx_q, dy_q, dz_q;
  logic                out_v_q;
  pnci_pkg::nbr_t      out_q;

  logic                emit;
  logic                last;
  logic                accept;
  pnci_pkg::nbr_t      nbr_d;

  assign emit   = hold_v_q && (!out_v_q || out_ready_i);
  assign last   = (dx_q == pnci_pkg::DIGIT_PLUS) && (dy_q == pnci_pkg::DIGIT_PLUS) &&
                  (dz_q == pnci_pkg::DIGIT_PLUS);
  assign in_ready_o = !hold_v_q || (emit && last);
  assign accept = in_valid_i && in_ready_o;

  always_comb begin
    nbr_d.pos.x = pnci_pkg::wrap_coord(pos_q.x, dx_q, dim_i);
    nbr_d.pos.y = pnci_pkg::wrap_coord(pos_q.y, dy_q, dim_i);
    nbr_d.pos.z = pnci_pkg::wrap_coord(pos_q.z, dz_q, dim_i);
    nbr_d.last  = last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hold_v_q <= 1'b0;
      out_v_q  <= 1'b0;
      dx_q     <= pnci_pkg::DIGIT_MINUS;
      dy_q     <= pnci_pkg::DIGIT_MINUS;
      dz_q     <= pnci_pkg::DIGIT_MINUS;
    end else begin
      if (accept) begin
        hold_v_q <= 1'b1;
        dx_q     <= pnci_pkg::DIGIT_MINUS;
        dy_q     <= pnci_pkg::DIGIT_MINUS;
        dz_q     <= pnci_pkg::DIGIT_MINUS;
      end else if (emit) begin
        if (last) begin
          hold_v_q <= 1'b0;
        end
        // x varies fastest, then y, then z.
        if (dx_q == pnci_pkg::DIGIT_PLUS) begin
          dx_q <= pnci_pkg::DIGIT_MINUS;
          if (dy_q == pnci_pkg::DIGIT_PLUS) begin
            dy_q <= pnci_pkg::DIGIT_MINUS;
            dz_q <= dz_q + 2'd1;
          end else begin
            dy_q <= dy_q + 2'd1;
          end
        end else begin
          dx_q <= dx_q + 2'd1;
        end
      end
      if (emit) begin
        out_v_q <= 1'b1;
      end else if (out_ready_i) begin
        out_v_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pos_q <= in_pos_i;
    end
    if (emit) begin
      out_q <= nbr_d;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_nbr_o   = out_q;

endmodule

[rtl/core/pnci_compose.sv]
// Two-stage multiply-add pipeline that rebuilds x + dim*(y + dim*z).
module pnci_compose (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  pnci_pkg::dim_t   dim_i,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  pnci_pkg::nbr_t   in_nbr_i,
  output logic             out_valid_o,
  input  logic             out_ready_i,
  output pnci_pkg::cell_t  out_cell_o,
  output logic             out_last_o
);

  localparam int unsigned M1_W = pnci_pkg::COORD_W + pnci_pkg::DIM_W;
  localparam int unsigned M2_W = pnci_pkg::PART_W + pnci_pkg::DIM_W;

  logic                           v1_q, v2_q;
  logic                           adv1, adv2;
  logic [pnci_pkg::PART_W-1:0]    part_q;
  logic [pnci_pkg::PART_W-1:0]    part_d;
  pnci_pkg::coord_t               x1_q;
  logic                           last1_q, last2_q;
  pnci_pkg::cell_t                cell_q;
  pnci_pkg::cell_t                cell_d;
  logic [M1_W-1:0]                zmul;
  logic [M2_W-1:0]                pmul;

  assign adv2 = !v2_q || out_ready_i;
  assign adv1 = !v1_q || adv2;

  always_comb begin
    zmul   = M1_W'(in_nbr_i.pos.z) * M1_W'(dim_i);
    part_d = pnci_pkg::PART_W'(zmul + M1_W'(in_nbr_i.pos.y));
    pmul   = M2_W'(part_q) * M2_W'(dim_i);
    cell_d = pnci_pkg::CELL_W'(pmul + M2_W'(x1_q));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (adv1) begin
        v1_q <= in_valid_i;
      end
      if (adv2) begin
        v2_q <= v1_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1 && in_valid_i) begin
      part_q  <= part_d;
      x1_q    <= in_nbr_i.pos.x;
      last1_q <= in_nbr_i.last;
    end
    if (adv2 && v1_q) begin
      cell_q  <= cell_d;
      last2_q <= last1_q;
    end
  end

  assign in_ready_o  = adv1;
  assign out_valid_o = v2_q;
  assign out_cell_o  = cell_q;
  assign out_last_o  = last2_q;

endmodule

[rtl/core/periodic_neighbor_cell_indices.sv]
// Top level of the periodic 27-cell neighborhood index generator.
// Path of an item: 13 registers lie between its acceptance and its first neighbor
// (9 divider stages, 1 sequencer load, 1 sequencer output register, 2 multiply-add stages).
// Throughput: one neighbor per cycle without output stalls, set by the offset sequencer;
// the next item is split in the divider pipeline while the current one is still emitted.
// Reset: asynchronous, active low; clears all valid bits and sets grid_dim to 16.
module periodic_neighbor_cell_indices (
  input  logic        clk_i,
  input  logic        rst_ni,
  // APB-style configuration port.
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  // Input stream.
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [17:0] home_cell, [23:18] zero
  // Output stream.
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [17:0] neighbor_cell, [23:18] zero
  output logic        m_axis_tlast    // is_last
);

  pnci_pkg::dim_t      grid_dim_q;
  pnci_pkg::dim_t      grid_dim_d;
  pnci_pkg::dim_t      dim_eff;
  logic                cfg_write;

  logic                split_valid;
  logic                split_ready;
  pnci_pkg::cell_xyz_t split_pos;

  logic                gen_valid;
  logic                gen_ready;
  pnci_pkg::nbr_t      gen_nbr;

  pnci_pkg::cell_t     out_cell;

  // Configuration: one register at byte address 0; other addresses ignore writes
  // and read as zero. The address bits below the word are not decoded.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready &&
                     (paddr[2] == pnci_pkg::REG_GRID_DIM);
  assign grid_dim_d = cfg_write ? pwdata[pnci_pkg::DIM_W-1:0] : grid_dim_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_dim_q <= pnci_pkg::DIM_W'(pnci_pkg::DIM_RESET);
    end else begin
      grid_dim_q <= grid_dim_d;
    end
  end

  always_comb begin
    if (paddr[2] == pnci_pkg::REG_GRID_DIM) begin
      prdata = {{(32 - pnci_pkg::DIM_W){1'b0}}, grid_dim_q};
    end else begin
      prdata = '0;
    end
  end

  // The user must change the effective dimension only while the block is idle; the
  // block does not enforce it. Every stage uses it directly, with no copy per item.
  assign dim_eff = pnci_pkg::eff_dim(grid_dim_q);

  // Divide the home cell by dim three times: the remainders are x, y and z,
  // and bits above the top axis drop out with the last quotient.
  pnci_split u_split (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dim_i       (dim_eff),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_cell_i   (s_axis_tdata[pnci_pkg::CELL_W-1:0]),
    .out_valid_o (split_valid),
    .out_ready_i (split_ready),
    .out_pos_o   (split_pos)
  );

  // Walk the offsets with x fastest and apply the periodic wrap on each axis.
  pnci_gen u_gen (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dim_i       (dim_eff),
    .in_valid_i  (split_valid),
    .in_ready_o  (split_ready),
    .in_pos_i    (split_pos),
    .out_valid_o (gen_valid),
    .out_ready_i (gen_ready),
    .out_nbr_o   (gen_nbr)
  );

  // Rebuild the linear index in Horner form; its last register is the output register.
  pnci_compose u_compose (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .dim_i       (dim_eff),
    .in_valid_i  (gen_valid),
    .in_ready_o  (gen_ready),
    .in_nbr_i    (gen_nbr),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_cell_o  (out_cell),
    .out_last_o  (m_axis_tlast)
  );

  assign m_axis_tdata = {{(pnci_pkg::TDATA_W - pnci_pkg::CELL_W){1'b0}}, out_cell};

  // The divider must leave every coordinate inside the grid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    split_valid |-> ((pnci_pkg::DIM_W'(split_pos.x) < dim_eff) &&
                     (pnci_pkg::DIM_W'(split_pos.y) < dim_eff) &&
                     (pnci_pkg::DIM_W'(split_pos.z) < dim_eff)))
    else $error("split coordinate outside the grid");

  // The periodic wrap must keep every neighbor coordinate inside the grid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gen_valid |-> ((pnci_pkg::DIM_W'(gen_nbr.pos.x) < dim_eff) &&
                   (pnci_pkg::DIM_W'(gen_nbr.pos.y) < dim_eff) &&
                   (pnci_pkg::DIM_W'(gen_nbr.pos.z) < dim_eff)))
    else $error("wrapped neighbor coordinate outside the grid");

  // A new home cell reaches the sequencer only when the previous one is finished.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (split_valid && split_ready && gen_valid && !gen_ready) |-> gen_nbr.last)
    else $error("sequencer took a new item before its last neighbor");

endmodule
